[design/sda_pkg.sv]
package sda_pkg;

  // Fixed field widths of the item and configuration beats
  localparam int COORD_W    = 16;
  localparam int DIST_W     = 32;
  localparam int ERR_SUM_W  = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 60;

  // One input beat: a point correspondence
  typedef struct packed {
    logic signed [COORD_W-1:0] x_col;
    logic signed [COORD_W-1:0] x_row;
    logic signed [COORD_W-1:0] y_col;
    logic signed [COORD_W-1:0] y_row;
    logic                      last_pair;
  } in_item_t;

  // One output beat: distance and running sum
  typedef struct packed {
    logic [DIST_W-1:0]    distance;
    logic [ERR_SUM_W-1:0] error_sum;
    logic                 sum_final;
    logic                 saturated;
  } out_item_t;

endpackage

[design/sampson_distance_accumulator_unit.sv]
// Sampson distance accumulator.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one point
// correspondence per beat; output channel (out_valid_o / out_stall_i /
// out_data_o) returns one result beat per input beat, in order.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes the three rows
// of the fundamental matrix; cfg_ready_o is always high. Write it only
// while no pair is in flight.
// Each pair runs through 17 products: 12 coordinate products, four
// squares of the lines and one square of the epipolar residual. A single
// shift-add multiplier works one multiplier bit per cycle over the serial
// operand's magnitude, and a restoring divider gives one quotient bit per
// cycle; when the quotient overflows, the divider stops after its first step.
// One pair is worked on at a time; the next pair is taken once the result
// has moved into the output register, even while that register still waits.
// A stalled receiver holds the result in the output register; a second
// finished result then waits in the core until the first beat is taken.
// Reset clears the matrix, the running sum and its clip flag, and empties
// the output register.
module sampson_distance_accumulator_unit
  import sda_pkg::*;
#(
  parameter int COORD_BITS     = 16,
  parameter int COEF_BITS      = 20,
  parameter int DIST_FRAC_BITS = 8,
  parameter int SUM_BITS       = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int C         = COEF_BITS;
  localparam int K         = COORD_BITS;
  localparam int L_W       = C + K + 1;
  localparam int S_W       = C + 2 * K + 2;
  localparam int ACC_W     = 2 * S_W;
  localparam int B_W       = S_W - 1;
  localparam int SQ_W      = 2 * S_W - 2;
  localparam int NUM_W     = SQ_W + DIST_FRAC_BITS;
  localparam int DEN_W     = 2 * C + 2 * K + 2;
  localparam int DIV_W     = (NUM_W > DEN_W + DIST_W) ? NUM_W : DEN_W + DIST_W;
  localparam int ROW_W     = 3 * C;
  localparam int CFG_EXT_W = (CFG_DATA_W > ROW_W) ? CFG_DATA_W : ROW_W;
  localparam int IN_EXT_W  = (COORD_W > K) ? COORD_W : K;
  localparam int SUM_EXT_W = (ERR_SUM_W > SUM_BITS) ? ERR_SUM_W : SUM_BITS;
  localparam int DIV_CNT_W = $clog2(DIST_W + 1);

  localparam logic [DIV_CNT_W-1:0] DIV_FIRST = DIV_CNT_W'(DIST_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_F_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_F_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_F_ROW2 = 2'd2;

  // Product steps of the sequencer
  typedef logic [4:0] term_t;
  localparam term_t T_L0_P0 = 5'd0;
  localparam term_t T_L0_P1 = 5'd1;
  localparam term_t T_L1_P0 = 5'd2;
  localparam term_t T_L1_P1 = 5'd3;
  localparam term_t T_L2_P0 = 5'd4;
  localparam term_t T_L2_P1 = 5'd5;
  localparam term_t T_M0_Q0 = 5'd6;
  localparam term_t T_M0_Q1 = 5'd7;
  localparam term_t T_M1_Q0 = 5'd8;
  localparam term_t T_M1_Q1 = 5'd9;
  localparam term_t T_S_Q0  = 5'd10;
  localparam term_t T_S_Q1  = 5'd11;
  localparam term_t T_D_L0  = 5'd12;
  localparam term_t T_D_L1  = 5'd13;
  localparam term_t T_D_M0  = 5'd14;
  localparam term_t T_D_M1  = 5'd15;
  localparam term_t T_N_S   = 5'd16;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_LOAD     = 6'b000010,
    ST_MUL      = 6'b000100,
    ST_DIV_INIT = 6'b001000,
    ST_DIV      = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_e;

  // Control state
  state_e               state_q, state_d;
  term_t                term_q, term_d;
  logic                 out_valid_q, out_valid_d;
  logic [SUM_BITS-1:0]  sum_q, sum_d;
  logic                 sum_clipped_q, sum_clipped_d;
  logic [ROW_W-1:0]     f_row_q [3];
  logic [ROW_W-1:0]     f_row_d [3];
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Datapath registers
  logic signed [K-1:0]     p0_q, p0_d, p1_q, p1_d, q0_q, q0_d, q1_q, q1_d;
  logic                    last_q, last_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [ACC_W-1:0]        a_q, a_d;
  logic [B_W-1:0]          b_q, b_d;
  logic signed [L_W-1:0]   l0_q, l0_d, l1_q, l1_d, l2_q, l2_d, m0_q, m0_d, m1_q, m1_d;
  logic signed [S_W-1:0]   s_q, s_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [DIV_W-1:0]        rem_q, rem_d, dvs_q, dvs_d;
  logic [DIST_W-1:0]       quo_q, quo_d;
  logic                    dist_sat_q, dist_sat_d;
  out_item_t               out_data_q, out_data_d;

  // Combinational helpers
  logic signed [C-1:0]     coef [3][3];
  logic [CFG_EXT_W-1:0]    cfg_ext;
  logic [IN_EXT_W-1:0]     xc_ext, xr_ext, yc_ext, yr_ext;
  logic signed [ACC_W-1:0] a_raw, bias;
  logic signed [S_W-1:0]   b_raw;
  logic                    first_term, b_neg;
  logic [S_W-1:0]          b_twos;
  logic [ACC_W-1:0]        a_eff;
  logic [DEN_W-1:0]        den_eff;
  logic                    div_ge;
  logic [SUM_BITS:0]       sum_ext;
  logic                    sum_ovf, clip_new;
  logic [SUM_BITS-1:0]     sum_new;
  logic [SUM_EXT_W-1:0]    sum_out;
  logic                    out_free;

  // Unpack matrix coefficients
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = f_row_q[r][c*C +: C];
      end
    end
  end

  assign cfg_ext = CFG_EXT_W'(cfg_data_i);
  assign xc_ext  = IN_EXT_W'($unsigned(in_data_i.x_col));
  assign xr_ext  = IN_EXT_W'($unsigned(in_data_i.x_row));
  assign yc_ext  = IN_EXT_W'($unsigned(in_data_i.y_col));
  assign yr_ext  = IN_EXT_W'($unsigned(in_data_i.y_row));

  // Select multiplicand and serial operand of the current product
  always_comb begin
    a_raw = '0;
    b_raw = '0;
    unique case (term_q)
      T_L0_P0: begin a_raw = ACC_W'(coef[0][0]); b_raw = S_W'(p0_q); end
      T_L0_P1: begin a_raw = ACC_W'(coef[0][1]); b_raw = S_W'(p1_q); end
      T_L1_P0: begin a_raw = ACC_W'(coef[1][0]); b_raw = S_W'(p0_q); end
      T_L1_P1: begin a_raw = ACC_W'(coef[1][1]); b_raw = S_W'(p1_q); end
      T_L2_P0: begin a_raw = ACC_W'(coef[2][0]); b_raw = S_W'(p0_q); end
      T_L2_P1: begin a_raw = ACC_W'(coef[2][1]); b_raw = S_W'(p1_q); end
      T_M0_Q0: begin a_raw = ACC_W'(coef[0][0]); b_raw = S_W'(q0_q); end
      T_M0_Q1: begin a_raw = ACC_W'(coef[1][0]); b_raw = S_W'(q1_q); end
      T_M1_Q0: begin a_raw = ACC_W'(coef[0][1]); b_raw = S_W'(q0_q); end
      T_M1_Q1: begin a_raw = ACC_W'(coef[1][1]); b_raw = S_W'(q1_q); end
      T_S_Q0:  begin a_raw = ACC_W'(l0_q);       b_raw = S_W'(q0_q); end
      T_S_Q1:  begin a_raw = ACC_W'(l1_q);       b_raw = S_W'(q1_q); end
      T_D_L0:  begin a_raw = ACC_W'(l0_q);       b_raw = S_W'(l0_q); end
      T_D_L1:  begin a_raw = ACC_W'(l1_q);       b_raw = S_W'(l1_q); end
      T_D_M0:  begin a_raw = ACC_W'(m0_q);       b_raw = S_W'(m0_q); end
      T_D_M1:  begin a_raw = ACC_W'(m1_q);       b_raw = S_W'(m1_q); end
      T_N_S:   begin a_raw = ACC_W'(s_q);        b_raw = S_W'(s_q);  end
      default: ;
    endcase
  end

  // Seed the accumulator at the first product of each sum
  always_comb begin
    first_term = 1'b0;
    bias       = '0;
    unique case (term_q)
      T_L0_P0: begin first_term = 1'b1; bias = ACC_W'(coef[0][2]); end
      T_L1_P0: begin first_term = 1'b1; bias = ACC_W'(coef[1][2]); end
      T_L2_P0: begin first_term = 1'b1; bias = ACC_W'(coef[2][2]); end
      T_M0_Q0: begin first_term = 1'b1; bias = ACC_W'(coef[2][0]); end
      T_M1_Q0: begin first_term = 1'b1; bias = ACC_W'(coef[2][1]); end
      T_S_Q0:  begin first_term = 1'b1; bias = ACC_W'(l2_q);       end
      T_D_L0:  first_term = 1'b1;
      T_N_S:   first_term = 1'b1;
      default: ;
    endcase
  end

  // Run the serial operand as a magnitude; move its sign onto the multiplicand
  assign b_neg   = b_raw[S_W-1];
  assign b_twos  = b_neg ? (~b_raw + S_W'(1)) : b_raw;
  assign a_eff   = b_neg ? (~a_raw + ACC_W'(1)) : a_raw;

  assign den_eff = (den_q == '0) ? DEN_W'(1) : den_q;
  assign div_ge  = (rem_q >= dvs_q);

  // Saturating running sum
  assign sum_ext  = {1'b0, sum_q} + (SUM_BITS + 1)'(quo_q);
  assign sum_ovf  = sum_ext[SUM_BITS];
  assign sum_new  = sum_ovf ? '1 : sum_ext[SUM_BITS-1:0];
  assign clip_new = sum_clipped_q | sum_ovf;
  assign sum_out  = SUM_EXT_W'(sum_new);

  assign out_free = !out_valid_q || !out_stall_i;

  // Next-state logic
  always_comb begin
    state_d       = state_q;
    term_d        = term_q;
    sum_d         = sum_q;
    sum_clipped_d = sum_clipped_q;
    cnt_d         = cnt_q;
    f_row_d       = f_row_q;
    p0_d          = p0_q;
    p1_d          = p1_q;
    q0_d          = q0_q;
    q1_d          = q1_q;
    last_d        = last_q;
    acc_d         = acc_q;
    a_d           = a_q;
    b_d           = b_q;
    l0_d          = l0_q;
    l1_d          = l1_q;
    l2_d          = l2_q;
    m0_d          = m0_q;
    m1_d          = m1_q;
    s_d           = s_q;
    den_d         = den_q;
    rem_d         = rem_q;
    dvs_d         = dvs_q;
    quo_d         = quo_q;
    dist_sat_d    = dist_sat_q;
    out_data_d    = out_data_q;

    // Drop the output beat once taken
    out_valid_d = out_valid_q && out_stall_i;

    // Take register writes; unknown indexes are ignored
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_F_ROW0: f_row_d[0] = cfg_ext[ROW_W-1:0];
        CFG_F_ROW1: f_row_d[1] = cfg_ext[ROW_W-1:0];
        CFG_F_ROW2: f_row_d[2] = cfg_ext[ROW_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        // Capture a new pair
        if (in_valid_i) begin
          p0_d    = xc_ext[K-1:0];
          p1_d    = xr_ext[K-1:0];
          q0_d    = yc_ext[K-1:0];
          q1_d    = yr_ext[K-1:0];
          last_d  = in_data_i.last_pair;
          term_d  = T_L0_P0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Bank the sum finished by the previous product
        unique case (term_q)
          T_L1_P0: l0_d  = acc_q[L_W-1:0];
          T_L2_P0: l1_d  = acc_q[L_W-1:0];
          T_M0_Q0: l2_d  = acc_q[L_W-1:0];
          T_M1_Q0: m0_d  = acc_q[L_W-1:0];
          T_S_Q0:  m1_d  = acc_q[L_W-1:0];
          T_D_L0:  s_d   = acc_q[S_W-1:0];
          T_N_S:   den_d = acc_q[DEN_W-1:0];
          default: ;
        endcase
        a_d = a_eff;
        b_d = b_twos[B_W-1:0];
        if (first_term) begin
          acc_d = bias;
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // Add one shifted multiplicand per operand bit
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
        if (b_q[B_W-1:1] == '0) begin
          if (term_q == T_N_S) begin
            state_d = ST_DIV_INIT;
          end else begin
            term_d  = term_q + term_t'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_DIV_INIT: begin
        rem_d      = DIV_W'(acc_q[SQ_W-1:0]) << DIST_FRAC_BITS;
        dvs_d      = DIV_W'(den_eff) << DIST_W;
        quo_d      = '0;
        dist_sat_d = 1'b0;
        cnt_d      = DIV_FIRST;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        // First step checks the quotient range, then one bit per cycle
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_FIRST) begin
          if (div_ge) begin
            dist_sat_d = 1'b1;
            quo_d      = '1;
            state_d    = ST_FINISH;
          end
        end else begin
          if (div_ge) begin
            rem_d = rem_q - dvs_q;
          end
          quo_d = {quo_q[DIST_W-2:0], div_ge};
          if (cnt_q == '0) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // Hand the result to the output register when it has room
        if (out_free) begin
          out_data_d.distance  = quo_q;
          out_data_d.error_sum = sum_out[ERR_SUM_W-1:0];
          out_data_d.sum_final = last_q;
          out_data_d.saturated = dist_sat_q | clip_new;
          out_valid_d          = 1'b1;
          sum_d                = last_q ? '0 : sum_new;
          sum_clipped_d        = last_q ? 1'b0 : clip_new;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      term_q        <= T_L0_P0;
      out_valid_q   <= 1'b0;
      sum_q         <= '0;
      sum_clipped_q <= 1'b0;
      cnt_q         <= '0;
      for (int r = 0; r < 3; r++) begin
        f_row_q[r] <= '0;
      end
    end else begin
      state_q       <= state_d;
      term_q        <= term_d;
      out_valid_q   <= out_valid_d;
      sum_q         <= sum_d;
      sum_clipped_q <= sum_clipped_d;
      cnt_q         <= cnt_d;
      f_row_q       <= f_row_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p0_q       <= p0_d;
    p1_q       <= p1_d;
    q0_q       <= q0_d;
    q1_q       <= q1_d;
    last_q     <= last_d;
    acc_q      <= acc_d;
    a_q        <= a_d;
    b_q        <= b_d;
    l0_q       <= l0_d;
    l1_q       <= l1_d;
    l2_q       <= l2_d;
    m0_q       <= m0_d;
    m1_q       <= m1_d;
    s_q        <= s_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    quo_q      <= quo_d;
    dist_sat_q <= dist_sat_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // Remainder stays below twice the current divisor during quotient steps
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != DIV_FIRST) |-> ({1'b0, rem_q} < {dvs_q, 1'b0}))
    else $error("divider remainder out of range");

  // A finished result waits while the output register is full and stalled
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> (state_q == ST_FINISH))
    else $error("result overwrote a pending output beat");

  // A clipped sum sits at its ceiling
  a_clip_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_clipped_q |-> (sum_q == '1))
    else $error("clip flag set with sum below ceiling");

  // The sequencer never runs past the last product
  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_MUL) |-> (term_q <= T_N_S))
    else $error("product step out of range");

endmodule

[sim/sampson_distance_accumulator_unit_tb.sv]
`timescale 1ns / 100ps

module sampson_distance_accumulator_unit_tb;
  import sda_pkg::*;

  localparam int COEF_BITS      = 20;
  localparam int DIST_FRAC_BITS = 8;
  localparam int SUM_BITS       = 48;

  localparam int PAIRS_PER_SETTING = 254;
  localparam int MAX_SET_LEN       = 24;
  localparam int END_WAIT_CYCLES   = 500;
  localparam longint TIMEOUT_NS    = 10_000_000;

  localparam logic [COORD_W-1:0]  C_MIN    = 16'h8000;
  localparam logic [COORD_W-1:0]  C_MAX    = 16'h7FFF;
  localparam logic [COEF_BITS-1:0] K_MAX   = 20'h7FFFF;
  localparam logic [COEF_BITS-1:0] K_MIN   = 20'h80000;
  localparam logic [SUM_BITS-1:0] SUM_CEIL = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_F_ROW0,
    REG_F_ROW1,
    REG_F_ROW2,
    REG_UNMAPPED
  } cfg_reg_e;

  typedef enum int {
    MAT_RAW,
    MAT_SMALL,
    MAT_SKEW,
    MAT_SPARSE
  } mat_style_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow of the matrix and the running sum
  logic [CFG_DATA_W-1:0] f_rows [3];
  logic [SUM_BITS-1:0]   running_err_sum;
  bit                    sum_hit_ceiling;

  out_item_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_errors      = 0;
  int n_checked     = 0;
  int n_sets        = 0;
  int n_saturated   = 0;
  int n_settings    = 0;

  sampson_distance_accumulator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Epipolar error of one correspondence, then fold it into the running sum
  function automatic out_item_t predict_sampson(input in_item_t pair);
    logic signed [127:0] fm [3][3];
    logic signed [127:0] xc, xr, yc, yr;
    logic signed [127:0] l0, l1, l2, m0, m1, resid;
    logic [191:0]        numer, denom;
    logic [DIST_W-1:0]   dist_val;
    bit                  dist_sat;
    logic [SUM_BITS:0]   nsum;
    out_item_t           res;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        fm[r][c] = $signed(f_rows[r][c*COEF_BITS +: COEF_BITS]);
      end
    end
    xc = $signed(pair.x_col);
    xr = $signed(pair.x_row);
    yc = $signed(pair.y_col);
    yr = $signed(pair.y_row);
    l0 = fm[0][0] * xc + fm[0][1] * xr + fm[0][2];
    l1 = fm[1][0] * xc + fm[1][1] * xr + fm[1][2];
    l2 = fm[2][0] * xc + fm[2][1] * xr + fm[2][2];
    m0 = fm[0][0] * yc + fm[1][0] * yr + fm[2][0];
    m1 = fm[0][1] * yc + fm[1][1] * yr + fm[2][1];
    resid = yc * l0 + yr * l1 + l2;
    numer = resid * resid;
    numer = numer << DIST_FRAC_BITS;
    denom = l0 * l0 + l1 * l1 + m0 * m0 + m1 * m1;
    // a zero denominator counts as one LSB
    if (denom == '0) begin
      denom = 192'd1;
    end
    dist_sat = (numer >= (denom << DIST_W));
    if (dist_sat) begin
      dist_val = '1;
    end else begin
      dist_val = DIST_W'(numer / denom);
    end
    nsum = running_err_sum + dist_val;
    if (nsum > SUM_CEIL) begin
      nsum = SUM_CEIL;
      sum_hit_ceiling = 1'b1;
    end
    running_err_sum = nsum[SUM_BITS-1:0];
    res.distance  = dist_val;
    res.error_sum = running_err_sum;
    res.sum_final = pair.last_pair;
    res.saturated = dist_sat | sum_hit_ceiling;
    // close the set
    if (pair.last_pair) begin
      running_err_sum = '0;
      sum_hit_ceiling = 1'b0;
    end
    return res;
  endfunction

  function automatic in_item_t pair_of(input logic [COORD_W-1:0] xc, xr, yc, yr,
                                       input logic last);
    in_item_t p;
    p.x_col     = xc;
    p.x_row     = xr;
    p.y_col     = yc;
    p.y_row     = yr;
    p.last_pair = last;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int v;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      v = $urandom();
    end else if (pick < 3) begin
      case ($urandom_range(0, 4))
        0: v = -32768;
        1: v = -1;
        2: v = 0;
        3: v = 1;
        default: v = 32767;
      endcase
    end else begin
      v = $urandom_range(0, 4095) - 2048;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic in_item_t rand_pair(input logic last, input bit on_line);
    in_item_t p;
    p = pair_of(rand_coord(), rand_coord(), rand_coord(), rand_coord(), last);
    // same point in both views: lies on its own epipolar line for a skew matrix
    if (on_line) begin
      p.y_col = p.x_col;
      p.y_row = p.x_row;
    end
    return p;
  endfunction

  // Send one correspondence beat and log its expected result on acceptance
  task automatic send_pair(input in_item_t pair);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pair;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_sampson(pair));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx != REG_UNMAPPED) begin
      f_rows[idx] = data;
    end
  endtask

  task automatic program_matrix(input logic [CFG_DATA_W-1:0] r0, r1, r2);
    write_reg(REG_F_ROW0, r0);
    write_reg(REG_F_ROW1, r1);
    write_reg(REG_F_ROW2, r2);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic choose_matrix(input mat_style_e style,
                               output logic [CFG_DATA_W-1:0] r0, r1, r2);
    int k [3][3];
    int t [3];
    logic [CFG_DATA_W-1:0] rows [3];
    for (int i = 0; i < 3; i++) begin
      t[i] = $urandom_range(0, 600) - 300;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        case (style)
          MAT_SMALL:  k[r][c] = $urandom_range(0, 255) - 128;
          MAT_SPARSE: k[r][c] = ($urandom_range(0, 9) < 7) ? 0 : $urandom();
          default:    k[r][c] = 0;
        endcase
      end
    end
    // cross-product matrix of a translation
    if (style == MAT_SKEW) begin
      k[0][1] = -t[2];
      k[0][2] = t[1];
      k[1][0] = t[2];
      k[1][2] = -t[0];
      k[2][0] = -t[1];
      k[2][1] = t[0];
    end
    for (int r = 0; r < 3; r++) begin
      if (style == MAT_RAW) begin
        rows[r] = CFG_DATA_W'({$urandom(), $urandom()});
      end else begin
        rows[r] = {k[r][2][COEF_BITS-1:0], k[r][1][COEF_BITS-1:0], k[r][0][COEF_BITS-1:0]};
      end
    end
    r0 = rows[0];
    r1 = rows[1];
    r2 = rows[2];
  endtask

  // Cleared matrix gives zero lines, so every distance is zero
  task automatic test_reset_matrix();
    send_pair(pair_of(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
    send_pair(pair_of(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0));
    send_pair(pair_of(C_MAX, C_MIN, '0, 16'hFFFF, 1'b1));
    drain();
  endtask

  // Only the constant term set: zero denominator, then quotient overflow
  task automatic test_zero_denominator();
    program_matrix('0, '0, {20'd4095, 40'd0});
    send_pair(pair_of(16'd1, 16'd2, 16'd3, 16'd4, 1'b0));
    send_pair(pair_of(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1));
    drain();
    program_matrix('0, '0, {20'd4096, 40'd0});
    send_pair(pair_of(16'd7, 16'd7, 16'd7, 16'd7, 1'b1));
    drain();
    program_matrix('0, '0, {K_MIN, 40'd0});
    send_pair(pair_of('0, '0, '0, '0, 1'b0));
    drain();
  endtask

  // Unmapped register index leaves the matrix alone
  task automatic test_unmapped_write();
    write_reg(REG_UNMAPPED, '1);
    cfg_valid_i <= 1'b0;
    send_pair(pair_of(16'd100, 16'hFF00, 16'd5, 16'd9, 1'b1));
    drain();
  endtask

  task automatic test_extreme_matrix();
    program_matrix({3{K_MAX}}, {3{K_MAX}}, {3{K_MAX}});
    send_pair(pair_of(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0));
    send_pair(pair_of(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
    send_pair(pair_of(C_MAX, C_MAX, C_MIN, C_MIN, 1'b0));
    send_pair(pair_of(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1));
    drain();
    program_matrix({3{K_MIN}}, {3{K_MIN}}, {3{K_MIN}});
    send_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MAX, 1'b0));
    send_pair(pair_of(C_MAX, C_MIN, C_MIN, C_MAX, 1'b0));
    send_pair(pair_of('0, '0, '0, '0, 1'b1));
    drain();
  endtask

  // Skew matrix: a point matched to itself lies on its line, distance zero
  task automatic test_on_line_pairs();
    program_matrix({20'd7, -20'sd5, 20'd0}, {20'd3, 20'd0, 20'd5}, {20'd0, -20'sd3, -20'sd7});
    send_pair(pair_of(16'd321, 16'hFE00, 16'd321, 16'hFE00, 1'b0));
    send_pair(pair_of(C_MIN, C_MAX, C_MIN, C_MAX, 1'b0));
    send_pair(pair_of(16'd321, 16'hFE00, 16'd322, 16'hFE01, 1'b1));
    drain();
  endtask

  // Sets of random length under two matrix settings
  task automatic test_random_sets(input int send_pct, input int recv_pct,
                                  input mat_style_e style_a, input mat_style_e style_b);
    logic [CFG_DATA_W-1:0] r0, r1, r2;
    mat_style_e style;
    int sent;
    int set_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 2; s++) begin
      style = (s == 0) ? style_a : style_b;
      choose_matrix(style, r0, r1, r2);
      program_matrix(r0, r1, r2);
      sent = 0;
      while (sent < PAIRS_PER_SETTING) begin
        set_len = $urandom_range(1, MAX_SET_LEN);
        if (set_len > PAIRS_PER_SETTING - sent) begin
          set_len = PAIRS_PER_SETTING - sent;
        end
        for (int i = 0; i < set_len; i++) begin
          send_pair(rand_pair(i == set_len - 1,
                              style == MAT_SKEW && $urandom_range(0, 1) == 1));
        end
        sent += set_len;
      end
      drain();
    end
  endtask

  // Take result beats and compare against the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending correspondence");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_data_o.distance);
          n_errors++;
        end
        if (out_data_o.error_sum !== want.error_sum) begin
          $error("error_sum: expected %0d, got %0d", want.error_sum, out_data_o.error_sum);
          n_errors++;
        end
        if (out_data_o.sum_final !== want.sum_final) begin
          $error("sum_final: expected %0d, got %0d", want.sum_final, out_data_o.sum_final);
          n_errors++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, out_data_o.saturated);
          n_errors++;
        end
        n_checked++;
        if (want.sum_final) begin
          n_sets++;
        end
        if (want.saturated) begin
          n_saturated++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    f_rows[0]       = '0;
    f_rows[1]       = '0;
    f_rows[2]       = '0;
    running_err_sum = '0;
    sum_hit_ceiling = 1'b0;
    send_idle_pct   = 33;
    recv_idle_pct   = 67;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_matrix();
    test_zero_denominator();
    test_unmapped_write();
    test_extreme_matrix();
    test_on_line_pairs();
    test_random_sets(33, 67, MAT_RAW, MAT_SKEW);
    test_random_sets(67, 33, MAT_SMALL, MAT_SPARSE);
    test_random_sets(0, 0, MAT_SKEW, MAT_RAW);

    // let any stray beat show up
    repeat (END_WAIT_CYCLES) @(posedge clk_i);

    $display("Checked %0d distance beats in %0d correspondence sets (%0d saturated)",
             n_checked, n_sets, n_saturated);
    $display("over %0d matrix settings and three sender/receiver stall mixes", n_settings);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
design/sda_pkg.sv
design/sampson_distance_accumulator_unit.sv
sim/sampson_distance_accumulator_unit_tb.sv
